>>> rtl/core/cbd_pkg.sv
// ----------------------------------------------------------------------------
// cbd_pkg: shared types and constants for the capability bounds decoder
// Field widths, stream widths and the decoded bound pair.
// ----------------------------------------------------------------------------
package cbd_pkg;

  localparam int RAW_W    = 27;
  localparam int ADDR_W   = 64;
  localparam int MANT_W   = 14;
  localparam int EXP_W    = 6;
  localparam int S_DATA_W = 96;   // 27 + 64 = 91, padded to whole bytes
  localparam int M_DATA_W = 128;

  typedef struct packed {
    logic [ADDR_W-1:0] top_addr;
    logic [ADDR_W-1:0] base_addr;
  } bounds_t;

endpackage

>>> rtl/core/capability_bounds_decode_top.sv
// Path from input accept to result valid: input register, then result register.
// Throughput: one item per cycle unless stalled; decode is a single shift/compare pass.
// The result register is stalled by m_axis_tready; the input side keeps accepting
// while the input register is empty or advancing.
// Reset (rst, synchronous, active high) clears both valid flags; data registers hold.
// ----------------------------------------------------------------------------
// capability_bounds_decode_top: compressed capability bounds decoder
// Unpacks a 27-bit bound word against a 64-bit cursor into base and top.
// ----------------------------------------------------------------------------
module capability_bounds_decode_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [26:0] bound_word, [90:27] cursor_addr, [95:91] zero
  input  logic [cbd_pkg::S_DATA_W-1:0] s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [63:0] base_addr, [127:64] top_addr
  output logic [cbd_pkg::M_DATA_W-1:0] m_axis_tdata
);

  // input register
  logic                        in_valid;
  logic [cbd_pkg::RAW_W-1:0]   bound_word;
  logic [cbd_pkg::ADDR_W-1:0]  cursor_addr;

  // result register
  logic                        out_valid;
  cbd_pkg::bounds_t            result;
  cbd_pkg::bounds_t            result_next;

  logic advance;

  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      bound_word  <= s_axis_tdata[cbd_pkg::RAW_W-1:0];
      cursor_addr <= s_axis_tdata[cbd_pkg::RAW_W+cbd_pkg::ADDR_W-1:cbd_pkg::RAW_W];
    end
  end

  // decode
  logic [2:0]                  f_be;
  logic [10:0]                 f_b;
  logic [2:0]                  f_te;
  logic [8:0]                  f_t;
  logic                        f_ie;
  logic [cbd_pkg::MANT_W-1:0]  bm;
  logic [cbd_pkg::MANT_W-1:0]  tm;
  logic [11:0]                 tlow;
  logic [cbd_pkg::EXP_W-1:0]   e;
  logic                        carry;
  logic [1:0]                  thi;
  logic [6:0]                  sh14;
  logic [6:0]                  sh11;
  logic [cbd_pkg::ADDR_W-1:0]  keep;
  logic [cbd_pkg::ADDR_W-1:0]  step;
  logic [cbd_pkg::ADDR_W-1:0]  top_raw;
  logic [cbd_pkg::ADDR_W-1:0]  base_raw;
  logic [cbd_pkg::ADDR_W-1:0]  addr_sh;
  logic [2:0]                  a3;
  logic [2:0]                  r3;
  logic                        cursor_low;
  logic                        top_low;
  logic                        base_low;

  always_comb begin
    f_be = bound_word[2:0];
    f_b  = bound_word[13:3];
    f_te = bound_word[16:14];
    f_t  = bound_word[25:17];
    f_ie = bound_word[26];

    if (f_ie) begin
      bm   = {f_b, 3'b000};
      tlow = {f_t, 3'b000};
      e    = {f_te, f_be};
    end else begin
      bm   = {f_b, f_be};
      tlow = {f_t, f_te};
      e    = '0;
    end

    // rebuild the top mantissa high bits, mod 4
    carry = (tlow < bm[11:0]);
    thi   = bm[13:12] + {1'b0, carry} + {1'b0, f_ie};
    tm    = {thi, tlow};

    sh14 = {1'b0, e} + 7'd14;
    sh11 = {1'b0, e} + 7'd11;

    // shifts of 64 or more give zero
    keep    = sh14[6] ? '0 : ({cbd_pkg::ADDR_W{1'b1}} << sh14[5:0]);
    step    = sh14[6] ? '0 : ({{(cbd_pkg::ADDR_W-1){1'b0}}, 1'b1} << sh14[5:0]);
    addr_sh = sh11[6] ? '0 : (cursor_addr >> sh11[5:0]);
    a3      = addr_sh[2:0];

    top_raw  = (cursor_addr & keep)
             | ({{(cbd_pkg::ADDR_W-cbd_pkg::MANT_W){1'b0}}, tm} << e);
    base_raw = (cursor_addr & keep)
             | ({{(cbd_pkg::ADDR_W-cbd_pkg::MANT_W){1'b0}}, bm} << e);

    r3         = bm[13:11] - 3'd1;
    cursor_low = (a3 < r3);
    top_low    = (tm[13:11] < r3);
    base_low   = (bm[13:11] < r3);

    // move each bound into the cursor's region
    if (!cursor_low && top_low) begin
      result_next.top_addr = top_raw + step;
    end else if (cursor_low && !top_low) begin
      result_next.top_addr = top_raw - step;
    end else begin
      result_next.top_addr = top_raw;
    end

    if (!cursor_low && base_low) begin
      result_next.base_addr = base_raw + step;
    end else if (cursor_low && !base_low) begin
      result_next.base_addr = base_raw - step;
    end else begin
      result_next.base_addr = base_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      result <= result_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = result;

endmodule

>>> rtl/core/cbd_checker.sv
// ----------------------------------------------------------------------------
// cbd_checker: port-level checks for the capability bounds decoder
// Watches the stream handshakes of the top level over time.
// ----------------------------------------------------------------------------
module cbd_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [cbd_pkg::M_DATA_W-1:0] m_axis_tdata
);

  // reset empties the result side
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // an empty result side never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");

  // an accepted item passes the input register and then the result register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |-> ##2 m_axis_tvalid)
    else $error("accepted item did not reach the result register");

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind capability_bounds_decode_top cbd_checker u_cbd_checker (.*);

>>> test/capability_bounds_decode_top_tb.sv
// ----------------------------------------------------------------------------
// capability_bounds_decode_top_tb: self-checking bench for the bounds decoder
// Streams compressed bound words and cursors into the decoder with random
// gaps and output stalls. Each accepted item is decoded by a local model of
// the compressed bounds decode, and the results are matched in order.
// ----------------------------------------------------------------------------
module capability_bounds_decode_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          MAX_WAIT      = 18;
  localparam int          RANDOM_ITEMS  = 550;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int          DRAIN_CYCLES  = 8;
  localparam logic [63:0] ALL_ONES      = 64'hFFFF_FFFF_FFFF_FFFF;

  logic                         clk;
  logic                         rst;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [cbd_pkg::S_DATA_W-1:0] s_axis_tdata;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  logic [cbd_pkg::M_DATA_W-1:0] m_axis_tdata;

  cbd_pkg::bounds_t bounds_q[$];
  int unsigned      mismatch_count;
  int unsigned      cycle_count;
  bit               send_calm;
  bit               recv_calm;

  capability_bounds_decode_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Shifts by 64 or more clear the word.
  function automatic logic [63:0] shl64(logic [63:0] v, int unsigned s);
    return (s >= 64) ? 64'd0 : (v << s);
  endfunction

  function automatic logic [63:0] shr64(logic [63:0] v, int unsigned s);
    return (s >= 64) ? 64'd0 : (v >> s);
  endfunction

  // Move a bound one region up or down depending on where it and the cursor sit.
  function automatic logic [63:0] region_fix(logic [63:0] bound, bit cursor_low,
                                             bit bound_low, logic [63:0] span);
    if (!cursor_low && bound_low) return bound + span;
    if (cursor_low && !bound_low) return bound - span;
    return bound;
  endfunction

  function automatic cbd_pkg::bounds_t decode_bounds(logic [cbd_pkg::RAW_W-1:0] raw,
                                                     logic [cbd_pkg::ADDR_W-1:0] cur);
    logic [2:0]                 lo_e, hi_e, ref_region, cur_region;
    logic [10:0]                b_field;
    logic [8:0]                 t_field;
    logic                       explicit_e, len_msb, carry;
    logic [cbd_pkg::MANT_W-1:0] bmant, tmant;
    logic [11:0]                tlow;
    logic [1:0]                 top_hi;
    int unsigned                e;
    logic [63:0]                keep, span, cur_shr;
    cbd_pkg::bounds_t           res;
    lo_e       = raw[2:0];
    b_field    = raw[13:3];
    hi_e       = raw[16:14];
    t_field    = raw[25:17];
    explicit_e = raw[26];
    if (explicit_e) begin
      e       = {26'd0, hi_e, lo_e};
      bmant   = {b_field, 3'b000};
      tlow    = {t_field, 3'b000};
      len_msb = 1'b1;
    end else begin
      e       = 0;
      bmant   = {b_field, lo_e};
      tlow    = {t_field, hi_e};
      len_msb = 1'b0;
    end
    carry  = tlow < bmant[11:0];
    top_hi = bmant[13:12] + {1'b0, carry} + {1'b0, len_msb};
    tmant  = {top_hi, tlow};

    keep          = shl64(shr64(ALL_ONES, e + 14), e + 14);
    res.base_addr = (cur & keep) | shl64({50'd0, bmant}, e);
    res.top_addr  = (cur & keep) | shl64({50'd0, tmant}, e);

    ref_region = bmant[13:11] - 3'd1;
    cur_shr    = shr64(cur, e + 11);
    cur_region = cur_shr[2:0];
    span       = shl64(64'd1, e + 14);
    res.top_addr  = region_fix(res.top_addr, cur_region < ref_region,
                               tmant[13:11] < ref_region, span);
    res.base_addr = region_fix(res.base_addr, cur_region < ref_region,
                               bmant[13:11] < ref_region, span);
    return res;
  endfunction

  function automatic logic [cbd_pkg::RAW_W-1:0] pack_raw(logic ie, logic [8:0] t,
                                                         logic [2:0] te, logic [10:0] b,
                                                         logic [2:0] be);
    return {ie, t, te, b, be};
  endfunction

  function automatic logic [cbd_pkg::RAW_W-1:0] explicit_raw(int unsigned e, logic [8:0] t,
                                                             logic [10:0] b);
    logic [5:0] ev;
    ev = e[5:0];
    return pack_raw(1'b1, t, ev[5:3], b, ev[2:0]);
  endfunction

  // Alternate between calm stretches with no waits and busy stretches.
  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 29) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] %s mismatch: got %h expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Entered and left at a rising edge; the item is accepted at the edge it returns on.
  task automatic send_bound_word(logic [cbd_pkg::RAW_W-1:0] raw,
                                 logic [cbd_pkg::ADDR_W-1:0] cur);
    int gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, cur, raw};
    do @(posedge clk); while (!s_axis_tready);
    bounds_q.push_back(decode_bounds(raw, cur));
  endtask

  task automatic test_exact_mode();
    send_bound_word('0, 64'd0);
    send_bound_word(pack_raw(1'b0, 9'h1FF, 3'd7, 11'h7FF, 3'd7), ALL_ONES);
    // top low bits above the base low bits: no carry into the top mantissa
    send_bound_word(pack_raw(1'b0, 9'h010, 3'd2, 11'h400, 3'd5), 64'h0123_4567_89AB_CDEF);
    send_bound_word(pack_raw(1'b0, 9'h155, 3'd5, 11'h2AA, 3'd2), 64'hAAAA_5555_AAAA_5555);
    send_bound_word(pack_raw(1'b0, 9'h0AA, 3'd2, 11'h555, 3'd5), 64'h5555_AAAA_5555_AAAA);
  endtask

  task automatic test_explicit_mode();
    send_bound_word(explicit_raw(0, 9'h1FF, 11'h7FF), 64'hFEDC_BA98_7654_3210);
    send_bound_word(explicit_raw(1, 9'h080, 11'h100), 64'h0000_0000_0001_2345);
    send_bound_word(explicit_raw(13, 9'h001, 11'h7F0), 64'h8000_0000_0000_0001);
    send_bound_word(explicit_raw(30, 9'h123, 11'h456), 64'h0F0F_F0F0_0F0F_F0F0);
    send_bound_word(explicit_raw(49, 9'h1F0, 11'h00F), ALL_ONES);
  endtask

  // Exponents where the cursor keep mask or region select run off the top.
  task automatic test_large_exponent();
    send_bound_word(explicit_raw(50, 9'h0F0, 11'h70F), 64'hC3C3_3C3C_C3C3_3C3C);
    send_bound_word(explicit_raw(52, 9'h1AB, 11'h3CD), ALL_ONES);
    send_bound_word(explicit_raw(53, 9'h111, 11'h222), 64'h7FFF_FFFF_FFFF_FFFF);
    send_bound_word(explicit_raw(63, 9'h1FF, 11'h7FF), ALL_ONES);
    send_bound_word(explicit_raw(63, 9'h000, 11'h000), 64'd0);
  endtask

  task automatic test_region_corrections();
    // cursor in the top region, both bounds below: both move up
    send_bound_word(pack_raw(1'b0, 9'h0FF, 3'd0, 11'h000, 3'd0), 64'h0000_0000_0000_3800);
    // cursor below the reference, bounds above: both move down
    send_bound_word(pack_raw(1'b0, 9'h1F0, 3'd1, 11'h400, 3'd3), 64'h1234_0000_0000_0000);
    send_bound_word(explicit_raw(20, 9'h0C0, 11'h000), 64'h0000_0003_8000_0000);
    send_bound_word(explicit_raw(40, 9'h1C0, 11'h500), 64'h0000_0800_0000_0000);
    // base wraps below zero
    send_bound_word(explicit_raw(45, 9'h100, 11'h200), 64'd0);
  endtask

  task automatic test_random();
    logic [31:0]               rnd;
    logic [cbd_pkg::RAW_W-1:0] raw;
    logic [63:0]               cur;
    int unsigned               e;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      rnd = $urandom();
      raw = rnd[cbd_pkg::RAW_W-1:0];
      cur = {$urandom(), $urandom()};
      if (raw[26]) begin
        case ($urandom_range(0, 4))
          0: e = $urandom_range(50, 63);
          1: e = $urandom_range(0, 3);
          default: e = $urandom_range(0, 49);
        endcase
        raw = explicit_raw(e, raw[25:17], raw[13:3]);
      end
      send_bound_word(raw, cur);
    end
  endtask

  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      int stall;
      stall = draw_wait(recv_calm);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk) begin
    cbd_pkg::bounds_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (bounds_q.size() == 0) begin
        report_mismatch("unexpected result", got.base_addr, 64'd0);
      end else begin
        want = bounds_q.pop_front();
        if (got.base_addr !== want.base_addr)
          report_mismatch("base_addr", got.base_addr, want.base_addr);
        if (got.top_addr !== want.top_addr)
          report_mismatch("top_addr", got.top_addr, want.top_addr);
      end
    end
  end

  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", bounds_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    mismatch_count = 0;
    send_calm      = 1'b0;
    recv_calm      = 1'b1;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_exact_mode();
    test_explicit_mode();
    test_large_exponent();
    test_region_corrections();
    test_random();
    s_axis_tvalid <= 1'b0;
    while (bounds_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/cbd_pkg.sv
rtl/core/capability_bounds_decode_top.sv
rtl/core/cbd_checker.sv
test/capability_bounds_decode_top_tb.sv
